[hdl/hdp_pkg.sv]
package hdp_pkg;

  // Sample lanes: one per sample in a byte at the narrowest depth
  localparam int LANES = 8;
  localparam int MAX_COMPONENTS_DEF = 4;

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 18;
  localparam int NV_W     = 4;

  // Depth codes
  localparam logic [2:0] DEPTH_1  = 3'd0;
  localparam logic [2:0] DEPTH_2  = 3'd1;
  localparam logic [2:0] DEPTH_4  = 3'd2;
  localparam logic [2:0] DEPTH_8  = 3'd3;
  localparam logic [2:0] DEPTH_16 = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_DEPTH      = 2'd0;
  localparam logic [1:0] REG_COMPONENTS = 2'd1;
  localparam logic [1:0] REG_COLUMNS    = 2'd2;
  localparam logic [1:0] REG_ROWS       = 2'd3;

  // Results of one input byte: one beat, or two at depth 16
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic       pair;
    logic       eor;
    logic       eoi;
  } beat_pair_t;

  function automatic logic [1:0] mod3(input logic [3:0] v);
    logic [1:0] r;
    case (v)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
      default:                              r = 2'd2;
    endcase
    return r;
  endfunction

  // v mod c for c in 1..4, v below 16
  function automatic logic [1:0] mod_comp(input logic [3:0] v, input logic [2:0] c);
    logic [1:0] r;
    case (c)
      3'd2:    r = {1'b0, v[0]};
      3'd3:    r = mod3(v);
      3'd4:    r = v[1:0];
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

[hdl/horizontal_difference_predictor_top.sv]
// Channel  | Handshake            | Payload                                  | Dir
// ---------+----------------------+------------------------------------------+----
// in       | in_valid / in_stall  | in_data_in[7:0]                          | in
// out      | out_valid / out_stall| out_data_out, out_last_of_run,           | out
//          |                      | out_end_of_row, out_end_of_image         |
// cfg      | cfg_wr_en            | cfg_index[1:0], cfg_data[15:0]           | in
//
// One input beat per cycle unless stalled; the byte's lanes and the state update
// settle in the accepting cycle, results are registered. A depth-16 low byte gives
// two output beats, its high byte none, so the output keeps pace at one beat/cycle
// while not stalled. Input stalls only when the two-entry result buffer is full.
// Reset (synchronous, rst_n low) restores register defaults and clears the stream;
// any config write also clears the stream so the next byte starts a new image.
module horizontal_difference_predictor_top
  import hdp_pkg::*;
#(
  parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_out,
  output logic        out_last_of_run,
  output logic        out_end_of_row,
  output logic        out_end_of_image
);

  localparam int CW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int SLOTS = 1 << CW;

  // config registers
  logic [2:0]  depth_r, comps_r;
  logic [15:0] cols_r, rows_r;

  // stream state
  logic [SAMPLE_W-1:0] prev_r [SLOTS];
  logic [CW-1:0]       ci_r, ci_nxt;
  logic [POS_W-1:0]    sd_r, sd_nxt;
  logic [15:0]         rc_r, rc_nxt;
  logic [7:0]          held_r;
  logic                pend_r;

  // derived config
  logic [2:0]          depth_eff, comps_eff;
  logic [15:0]         cols_eff, rows_eff;
  logic [POS_W-1:0]    total;
  logic [SAMPLE_W-1:0] mask;
  logic [NV_W-1:0]     spb, n_valid;

  logic [POS_W-1:0]    remaining;
  logic [15:0]         rc_inc;
  logic                eor, eoi, is_hi, acc, push, buf_full;

  logic [SAMPLE_W-1:0] lane_cur  [LANES];
  logic [SAMPLE_W-1:0] lane_prev [LANES];
  logic [SAMPLE_W-1:0] lane_diff [LANES];
  logic [CW-1:0]       lane_slot [LANES];
  logic [LANES-1:0]    lane_vld;
  logic [SAMPLE_W-1:0] prev_upd  [SLOTS];
  beat_pair_t          entry;

  // out-of-range settings fold to legal ones
  always_comb begin
    depth_eff = (depth_r > DEPTH_16) ? DEPTH_8 : depth_r;
    if (comps_r == 3'd0)                      comps_eff = 3'd1;
    else if (comps_r > 3'(MAX_COMPONENTS))    comps_eff = 3'(MAX_COMPONENTS);
    else                                      comps_eff = comps_r;
    cols_eff = (cols_r == 16'd0) ? 16'd1 : cols_r;
    rows_eff = (rows_r == 16'd0) ? 16'd1 : rows_r;
  end

  // samples per row: columns times 1..4, shifts and one add
  always_comb begin
    case (comps_eff)
      3'd2:    total = {1'b0, cols_eff, 1'b0};
      3'd3:    total = {1'b0, cols_eff, 1'b0} + {2'b00, cols_eff};
      3'd4:    total = {cols_eff, 2'b00};
      default: total = {2'b00, cols_eff};
    endcase
  end

  always_comb begin
    case (depth_eff)
      DEPTH_1:  begin mask = 16'h0001; spb = 4'd8; end
      DEPTH_2:  begin mask = 16'h0003; spb = 4'd4; end
      DEPTH_4:  begin mask = 16'h000f; spb = 4'd2; end
      DEPTH_16: begin mask = 16'hffff; spb = 4'd1; end
      default:  begin mask = 16'h00ff; spb = 4'd1; end
    endcase
  end

  // row position: the byte ends the row once its samples reach the row total
  assign remaining = total - sd_r;
  assign eor       = (remaining <= POS_W'(spb));
  assign n_valid   = eor ? remaining[NV_W-1:0] : spb;
  assign rc_inc    = rc_r + 16'd1;
  assign eoi       = eor && (rc_inc >= rows_eff);

  always_comb begin
    ci_nxt = CW'(mod_comp(4'(ci_r) + n_valid, comps_eff));
    sd_nxt = sd_r + POS_W'(n_valid);
    rc_nxt = eoi ? 16'd0 : rc_inc;
  end

  // high byte of a 16-bit sample is only held
  assign is_hi = (depth_eff == DEPTH_16) && !pend_r;
  assign in_stall = buf_full;
  assign acc   = in_valid && !in_stall;
  assign push  = acc && !is_hi;

  // lanes: sample j of the byte, MSB first
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    always_comb begin
      case (depth_eff)
        DEPTH_1:  lane_cur[j] = {15'd0, in_data_in[7-j]};
        DEPTH_2:  lane_cur[j] = {14'd0, in_data_in[7-2*(j%4) -: 2]};
        DEPTH_4:  lane_cur[j] = {12'd0, in_data_in[7-4*(j%2) -: 4]};
        DEPTH_16: lane_cur[j] = {held_r, in_data_in};
        default:  lane_cur[j] = {8'd0, in_data_in};
      endcase
    end

    assign lane_slot[j] = CW'(mod_comp(4'(ci_r) + 4'(j), comps_eff));
    assign lane_vld[j]  = (4'(j) < n_valid);

    // same component one pixel back: earlier lane of this byte, else stored value
    always_comb begin
      lane_prev[j] = prev_r[lane_slot[j]];
      for (int i = 0; i < j; i++)
        if (4'(i) + {1'b0, comps_eff} == 4'(j)) lane_prev[j] = lane_cur[i];
    end

    hdp_lane u_lane (
      .cur  (lane_cur[j]),
      .prev (lane_prev[j]),
      .mask (mask),
      .diff (lane_diff[j])
    );
  end

  hdp_merge #(
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_merge (
    .depth     (depth_eff),
    .lane_cur  (lane_cur),
    .lane_diff (lane_diff),
    .lane_vld  (lane_vld),
    .lane_slot (lane_slot),
    .prev_cur  (prev_r),
    .eor       (eor),
    .eoi       (eoi),
    .entry     (entry),
    .prev_upd  (prev_upd)
  );

  hdp_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (entry),
    .full       (buf_full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data_out),
    .out_last   (out_last_of_run),
    .out_eor    (out_end_of_row),
    .out_eoi    (out_end_of_image)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= DEPTH_8;
      comps_r <= 3'd1;
      cols_r  <= 16'd1;
      rows_r  <= 16'd1;
      for (int s = 0; s < SLOTS; s++) prev_r[s] <= '0;
      ci_r    <= '0;
      sd_r    <= '0;
      rc_r    <= '0;
      pend_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEPTH:      depth_r <= cfg_data[2:0];
        REG_COMPONENTS: comps_r <= cfg_data[2:0];
        REG_COLUMNS:    cols_r  <= cfg_data;
        REG_ROWS:       rows_r  <= cfg_data;
        default:        ;
      endcase
      for (int s = 0; s < SLOTS; s++) prev_r[s] <= '0;
      ci_r   <= '0;
      sd_r   <= '0;
      rc_r   <= '0;
      pend_r <= 1'b0;
    end else if (acc) begin
      if (is_hi) begin
        pend_r <= 1'b1;
      end else begin
        pend_r <= 1'b0;
        prev_r <= prev_upd;
        if (eor) begin
          ci_r <= '0;
          sd_r <= '0;
          rc_r <= rc_nxt;
        end else begin
          ci_r <= ci_nxt;
          sd_r <= sd_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && is_hi) held_r <= in_data_in;
  end

  a_pos_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    sd_r < total) else $error("row position beyond row length");

  a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
    3'(ci_r) < comps_eff) else $error("component index beyond component count");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    rc_r < rows_eff) else $error("row counter beyond image height");

  a_pend_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (depth_eff == DEPTH_16)) else $error("held high byte outside depth 16");

endmodule

[hdl/hdp_lane.sv]
module hdp_lane
  import hdp_pkg::*;
(
  input  logic [SAMPLE_W-1:0] cur,
  input  logic [SAMPLE_W-1:0] prev,
  input  logic [SAMPLE_W-1:0] mask,
  output logic [SAMPLE_W-1:0] diff
);

  // difference modulo 2^depth
  assign diff = (cur - prev) & mask;

endmodule

[hdl/hdp_merge.sv]
module hdp_merge
  import hdp_pkg::*;
#(
  parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF
)
(
  input  logic [2:0]                 depth,
  input  logic [SAMPLE_W-1:0]        lane_cur  [LANES],
  input  logic [SAMPLE_W-1:0]        lane_diff [LANES],
  input  logic [LANES-1:0]           lane_vld,
  input  logic [((MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1)-1:0] lane_slot [LANES],
  input  logic [SAMPLE_W-1:0]
                 prev_cur [1 << ((MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1)],
  input  logic                       eor,
  input  logic                       eoi,
  output beat_pair_t                 entry,
  output logic [SAMPLE_W-1:0]
                 prev_upd [1 << ((MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1)]
);

  localparam int CW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int SLOTS = 1 << CW;

  logic [7:0] res;

  // pack lane differences into the result byte; padding stays zero
  always_comb begin
    res          = 8'd0;
    entry.second = 8'd0;
    entry.pair   = 1'b0;
    case (depth)
      DEPTH_1: begin
        for (int j = 0; j < LANES; j++)
          if (lane_vld[j]) res[7-j] = lane_diff[j][0];
      end
      DEPTH_2: begin
        for (int j = 0; j < LANES/2; j++)
          if (lane_vld[j]) res[7-2*j -: 2] = lane_diff[j][1:0];
      end
      DEPTH_4: begin
        for (int j = 0; j < LANES/4; j++)
          if (lane_vld[j]) res[7-4*j -: 4] = lane_diff[j][3:0];
      end
      DEPTH_16: begin
        res          = lane_diff[0][15:8];
        entry.second = lane_diff[0][7:0];
        entry.pair   = 1'b1;
      end
      default: res = lane_diff[0][7:0];
    endcase
    entry.first = res;
    entry.eor   = eor;
    entry.eoi   = eoi;
  end

  // latest valid lane of each component wins; row end clears all
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      prev_upd[s] = prev_cur[s];
      for (int j = 0; j < LANES; j++)
        if (lane_vld[j] && lane_slot[j] == CW'(s)) prev_upd[s] = lane_cur[j];
      if (eor) prev_upd[s] = '0;
    end
  end

endmodule

[hdl/hdp_out_fifo.sv]
module hdp_out_fifo
  import hdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  beat_pair_t push_entry,
  output logic       full,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data,
  output logic       out_last,
  output logic       out_eor,
  output logic       out_eoi
);

  beat_pair_t ent_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       phase_r, phase_nxt;
  beat_pair_t cur_ent;
  logic       take, pop;

  assign cur_ent   = ent_r[rd_ptr_r];
  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = phase_r ? cur_ent.second : cur_ent.first;
  assign out_last  = !cur_ent.pair || phase_r;
  assign out_eor   = cur_ent.eor;
  assign out_eoi   = cur_ent.eoi;

  assign take = out_valid && !out_stall;
  assign pop  = take && out_last;

  always_comb begin
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
    phase_nxt = take ? !pop : phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      phase_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      phase_r <= phase_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_entry;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full result buffer");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("result buffer count out of range");

  a_phase_pair: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (out_valid && cur_ent.pair))
    else $error("second beat without a paired entry");

endmodule
